@@ rtl/mfr_pkg.sv @@
// mfr_pkg: shared types, codes and crc helper for the multiplex frame receiver
// no dependencies
package mfr_pkg;

  localparam int FrameBytes   = 256;
  localparam int CommandBytes = 256;

  localparam logic [7:0] Hdr1 = 8'h54;
  localparam logic [7:0] Hdr2 = 8'hab;

  localparam logic [0:0] CfgOwnId  = 1'b0;
  localparam logic [0:0] CfgSubCode = 1'b1;

  typedef enum logic [3:0] {
    PH_H1, PH_H2, PH_SRC, PH_DST, PH_SIZE, PH_SUB, PH_CHAN, PH_LEN,
    PH_PAY, PH_REST, PH_CRCLO, PH_CRCHI
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_LARGE = 4'd1, ST_CRC = 4'd2, ST_NOTOURS = 4'd3,
    ST_SUB = 4'd4, ST_CHAN = 4'd5, ST_LEN = 4'd6, ST_OVER = 4'd7,
    ST_MALF = 4'd8
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [3:0] status;
    logic       is_query;
    logic [6:0] reply_id;
    logic [8:0] payload_count;
  } event_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [3:0] status;
    logic       is_query;
    logic [6:0] reply_id;
    logic [8:0] payload_count;
    logic [8:0] command_fill;
  } result_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ rtl/multiplex_frame_receiver_unit.sv @@
// multiplex_frame_receiver_unit: top level, parser front, queue, fill-accounting back
// depends on mfr_pkg, mfr_front, mfr_queue, mfr_back
// one byte per cycle while the event register is free or being taken; crc and parse step are combinational
// a result is registered in the event reg at the edge that accepts its byte,
// then written to the queue, then loaded into the output reg
// synchronous reset returns parser to header hunt, crc to ffff, fill to zero
// reset sets own_id to 1 and client_subframe_code to 0x40
module multiplex_frame_receiver_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic [3:0] status,
  output logic       is_query,
  output logic [6:0] reply_id,
  output logic [8:0] payload_count,
  output logic [8:0] command_fill
);

  logic [7:0] own_id;
  logic [6:0] sub_code;
  logic ev_valid, ev_ready, q_valid, q_ready;
  mfr_pkg::event_t ev, q_data;
  mfr_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= 8'd1; sub_code <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfr_pkg::CfgOwnId:   own_id <= cfg_data;
        mfr_pkg::CfgSubCode: sub_code <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  mfr_front u_front (
    .clk, .rst, .in_valid, .in_ready, .rx_byte, .own_id,
    .client_subframe_code(sub_code), .ev_valid, .ev_ready, .ev
  );

  mfr_queue u_queue (
    .clk, .rst, .wr_valid(ev_valid), .wr_ready(ev_ready), .wr_data(ev),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  mfr_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign kind = res.kind;
  assign data_byte = res.data_byte;
  assign status = res.status;
  assign is_query = res.is_query;
  assign reply_id = res.reply_id;
  assign payload_count = res.payload_count;
  assign command_fill = res.command_fill;

endmodule

@@ rtl/mfr_front.sv @@
// mfr_front: byte parser, crc and frame checks; emits payload and pre-verdict events
// depends on mfr_pkg
module mfr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        own_id,
  input  logic [6:0]        client_subframe_code,
  output logic              ev_valid,
  input  logic              ev_ready,
  output mfr_pkg::event_t   ev
);

  mfr_pkg::phase_t phase, phase_next;
  logic [15:0] crc, crc_next;
  logic [31:0] acc, acc_next;
  logic [2:0]  shc, shc_next;
  logic [31:0] fsize, fsize_next;
  logic [8:0]  consumed, consumed_next;
  logic [3:0]  hlen, hlen_next;
  logic [7:0]  src, src_next;
  logic        dmatch, dmatch_next;
  logic [3:0]  ierr, ierr_next;
  logic [8:0]  remain, remain_next;
  logic [7:0]  crclo, crclo_next;

  logic        take;
  logic        emit;
  mfr_pkg::event_t ev_d;

  logic [2:0]  sh;
  logic [31:0] acc_f;
  logic [1:0]  vr;
  logic [15:0] crc_b;
  logic [31:0] lim;

  assign in_ready = !ev_valid || ev_ready;
  assign take = in_valid && in_ready;

  always_comb begin
    sh = (shc > 3'd4) ? 3'd4 : shc;
    unique case (sh)
      3'd0: acc_f = acc | {25'd0, rx_byte[6:0]};
      3'd1: acc_f = acc | {18'd0, rx_byte[6:0], 7'd0};
      3'd2: acc_f = acc | {11'd0, rx_byte[6:0], 14'd0};
      3'd3: acc_f = acc | {4'd0, rx_byte[6:0], 21'd0};
      default: acc_f = acc | {rx_byte[3:0], 28'd0};
    endcase
    if (!rx_byte[7]) vr = 2'd1;
    else if (sh >= 3'd4) vr = 2'd2;
    else vr = 2'd0;
  end

  always_comb begin
    phase_next = phase; crc_next = crc; acc_next = acc; shc_next = shc;
    fsize_next = fsize; consumed_next = consumed; hlen_next = hlen;
    src_next = src; dmatch_next = dmatch; ierr_next = ierr;
    remain_next = remain; crclo_next = crclo;
    emit = 1'b0;
    ev_d = '0;
    ev_d.is_query = src[7];
    ev_d.reply_id = src[6:0];
    crc_b = mfr_pkg::crc_update(crc, rx_byte);
    lim = 32'(mfr_pkg::FrameBytes) - {28'd0, hlen_next};
    unique case (phase)
      mfr_pkg::PH_H1: begin
        if (rx_byte == mfr_pkg::Hdr1) begin
          crc_next = mfr_pkg::crc_update(16'hffff, rx_byte);
          phase_next = mfr_pkg::PH_H2;
        end
      end
      mfr_pkg::PH_H2: begin
        crc_next = crc_b;
        phase_next = (rx_byte == mfr_pkg::Hdr2) ? mfr_pkg::PH_SRC : mfr_pkg::PH_H1;
      end
      mfr_pkg::PH_SRC: begin
        crc_next = crc_b; src_next = rx_byte; phase_next = mfr_pkg::PH_DST;
      end
      mfr_pkg::PH_DST: begin
        crc_next = crc_b; dmatch_next = (rx_byte == own_id);
        acc_next = '0; shc_next = '0; hlen_next = 4'd4;
        phase_next = mfr_pkg::PH_SIZE;
      end
      mfr_pkg::PH_SIZE: begin
        crc_next = crc_b;
        hlen_next = hlen + 4'd1;
        lim = 32'(mfr_pkg::FrameBytes) - {28'd0, hlen_next};
        if (vr == 2'd0) begin
          acc_next = acc_f; shc_next = sh + 3'd1;
        end else begin
          fsize_next = (vr == 2'd1) ? acc_f : 32'hffffffff;
          acc_next = '0; shc_next = '0;
          if (fsize_next > lim) begin
            phase_next = mfr_pkg::PH_H1;
            emit = 1'b1;
            ev_d.kind = 1'b1;
            ev_d.status = mfr_pkg::ST_LARGE;
          end else begin
            consumed_next = '0; ierr_next = mfr_pkg::ST_OK; remain_next = '0;
            if (fsize_next == 32'd0) begin
              ierr_next = mfr_pkg::ST_MALF; phase_next = mfr_pkg::PH_CRCLO;
            end else begin
              phase_next = mfr_pkg::PH_SUB;
            end
          end
        end
      end
      mfr_pkg::PH_SUB, mfr_pkg::PH_CHAN, mfr_pkg::PH_LEN,
      mfr_pkg::PH_PAY, mfr_pkg::PH_REST: begin
        crc_next = crc_b;
        consumed_next = consumed + 9'd1;
        if (phase == mfr_pkg::PH_PAY) begin
          emit = 1'b1;
          ev_d = '0;
          ev_d.data_byte = rx_byte;
          if (remain <= 9'd1) begin
            remain_next = '0; phase_next = mfr_pkg::PH_REST;
          end else begin
            remain_next = remain - 9'd1;
          end
        end else if (phase != mfr_pkg::PH_REST) begin
          if (vr == 2'd2) begin
            acc_next = acc_f;
            if (ierr == mfr_pkg::ST_OK) ierr_next = mfr_pkg::ST_MALF;
            phase_next = mfr_pkg::PH_REST;
          end else if (vr == 2'd0) begin
            acc_next = acc_f; shc_next = sh + 3'd1;
          end else if (phase == mfr_pkg::PH_SUB) begin
            acc_next = '0; shc_next = '0;
            if (acc_f != {25'd0, client_subframe_code}) begin
              if (ierr == mfr_pkg::ST_OK) ierr_next = mfr_pkg::ST_SUB;
              phase_next = mfr_pkg::PH_REST;
            end else phase_next = mfr_pkg::PH_CHAN;
          end else if (phase == mfr_pkg::PH_CHAN) begin
            acc_next = '0; shc_next = '0;
            if (acc_f != 32'd1) begin
              if (ierr == mfr_pkg::ST_OK) ierr_next = mfr_pkg::ST_CHAN;
              phase_next = mfr_pkg::PH_REST;
            end else phase_next = mfr_pkg::PH_LEN;
          end else begin
            acc_next = acc_f;
            if (acc_f > fsize - {23'd0, consumed_next}) begin
              if (ierr == mfr_pkg::ST_OK) ierr_next = mfr_pkg::ST_LEN;
              phase_next = mfr_pkg::PH_REST;
            end else begin
              remain_next = acc_f[8:0];
              phase_next = (acc_f != 32'd0) ? mfr_pkg::PH_PAY : mfr_pkg::PH_REST;
            end
          end
        end
        if ({23'd0, consumed_next} >= fsize) begin
          if (phase_next == mfr_pkg::PH_SUB || phase_next == mfr_pkg::PH_CHAN ||
              phase_next == mfr_pkg::PH_LEN) begin
            if (ierr_next == mfr_pkg::ST_OK) ierr_next = mfr_pkg::ST_MALF;
          end
          phase_next = mfr_pkg::PH_CRCLO;
        end
      end
      mfr_pkg::PH_CRCLO: begin
        crclo_next = rx_byte; phase_next = mfr_pkg::PH_CRCHI;
      end
      mfr_pkg::PH_CRCHI: begin
        phase_next = mfr_pkg::PH_H1;
        emit = 1'b1;
        ev_d.kind = 1'b1;
        ev_d.payload_count = (ierr == mfr_pkg::ST_OK) ? acc[8:0] : 9'd0;
        if ({rx_byte, crclo} != crc) ev_d.status = mfr_pkg::ST_CRC;
        else if (!dmatch) ev_d.status = mfr_pkg::ST_NOTOURS;
        else ev_d.status = ierr;
      end
      default: phase_next = mfr_pkg::PH_H1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mfr_pkg::PH_H1; crc <= 16'hffff; acc <= '0; shc <= '0;
      fsize <= '0; consumed <= '0; hlen <= '0; src <= '0; dmatch <= 1'b0;
      ierr <= mfr_pkg::ST_OK; remain <= '0; crclo <= '0; ev_valid <= 1'b0;
    end else begin
      if (ev_valid && ev_ready) ev_valid <= 1'b0;
      if (take) begin
        phase <= phase_next; crc <= crc_next; acc <= acc_next; shc <= shc_next;
        fsize <= fsize_next; consumed <= consumed_next; hlen <= hlen_next;
        src <= src_next; dmatch <= dmatch_next; ierr <= ierr_next;
        remain <= remain_next; crclo <= crclo_next;
        if (emit) ev_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) ev <= ev_d;
  end

endmodule

@@ rtl/mfr_queue.sv @@
// mfr_queue: two-entry request queue between parser and verdict stage
// depends on mfr_pkg
module mfr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  mfr_pkg::event_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output mfr_pkg::event_t rd_data
);

  mfr_pkg::event_t mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       wr, rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; count <= '0;
    end else begin
      if (wr) wptr <= !wptr;
      if (rd) rptr <= !rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wr_data;
  end

endmodule

@@ rtl/mfr_back.sv @@
// mfr_back: command fill accounting and output register
// depends on mfr_pkg
module mfr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  mfr_pkg::event_t   q_data,
  output logic              res_valid,
  input  logic              res_ready,
  output mfr_pkg::result_t  res
);

  logic [8:0]  fill, fill_next;
  logic [9:0]  sum;
  mfr_pkg::result_t r;
  logic take;

  assign q_ready = !res_valid || res_ready;
  assign take = q_valid && q_ready;

  always_comb begin
    sum = {1'b0, fill} + {1'b0, q_data.payload_count};
    fill_next = fill;
    r = '{kind: q_data.kind, data_byte: q_data.data_byte, status: q_data.status,
          is_query: q_data.is_query, reply_id: q_data.reply_id,
          payload_count: q_data.payload_count, command_fill: 9'd0};
    if (q_data.kind) begin
      if (q_data.status == mfr_pkg::ST_OK) begin
        if (sum > 10'(mfr_pkg::CommandBytes)) begin
          r.status = mfr_pkg::ST_OVER; fill_next = '0;
        end else fill_next = sum[8:0];
      end
      r.command_fill = fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0; res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (take) begin
        res_valid <= 1'b1; fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res <= r;
  end

endmodule

@@ rtl/mfr_checker.sv @@
// mfr_checker: port-level assertions for the frame receiver
// depends on multiplex_frame_receiver_unit ports
module mfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [7:0] data_byte,
  input logic [3:0] status,
  input logic [8:0] payload_count,
  input logic [8:0] command_fill
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_byte))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> status <= mfr_pkg::ST_MALF)
    else $error("bad status code");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> command_fill <= 9'(mfr_pkg::CommandBytes))
    else $error("fill out of range");

  a_pay: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> status == mfr_pkg::ST_OK && command_fill == 9'd0 &&
    payload_count == 9'd0)
    else $error("payload request carries verdict fields");

  a_over: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind && status == mfr_pkg::ST_OVER |-> command_fill == 9'd0)
    else $error("overflow without fill clear");

endmodule

bind multiplex_frame_receiver_unit mfr_checker u_mfr_checker (
  .clk, .rst, .out_valid, .out_ready, .kind, .data_byte, .status,
  .payload_count, .command_fill
);

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for multiplex_frame_receiver_unit
// depends on mfr_pkg and the receiver rtl; byte-level predictor, directed table then random frames
module tb_top;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;
  logic       out_valid;
  logic       out_ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [3:0] status;
  logic       is_query;
  logic [6:0] reply_id;
  logic [8:0] payload_count;
  logic [8:0] command_fill;

  multiplex_frame_receiver_unit u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .data_byte(data_byte),
    .status(status), .is_query(is_query), .reply_id(reply_id),
    .payload_count(payload_count), .command_fill(command_fill)
  );

  // predictor state
  logic [7:0]  m_own;
  logic [6:0]  m_sub;
  mfr_pkg::phase_t m_ph;
  logic [15:0] m_crc;
  logic [31:0] m_acc;
  logic [2:0]  m_sh;
  logic [31:0] m_size;
  logic [8:0]  m_used;
  logic [3:0]  m_hlen;
  logic [7:0]  m_src;
  logic        m_dmatch;
  logic [3:0]  m_err;
  logic [8:0]  m_left;
  logic [7:0]  m_crclo;
  logic [8:0]  m_fill;

  mfr_pkg::result_t expected_q[$];
  logic    failed;
  int      send_idle, recv_idle;
  bit      hold_recv;

  // frame builder buffer
  logic [7:0] frame_buf[$];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
    return x;
  endfunction

  // 0 in progress, 1 done, 2 too long
  function automatic int varuint_feed(input logic [7:0] b);
    logic [2:0] s;
    s = (m_sh > 3'd4) ? 3'd4 : m_sh;
    m_acc = m_acc | ({25'd0, b[6:0]} << (7 * s));
    if (!b[7]) return 1;
    if (s >= 3'd4) return 2;
    m_sh = s + 3'd1;
    return 0;
  endfunction

  function automatic void inner_fail(input logic [3:0] e);
    if (m_err == mfr_pkg::ST_OK) m_err = e;
    m_ph = mfr_pkg::PH_REST;
  endfunction

  function automatic void predictor_reset();
    m_own = 8'd1; m_sub = 7'd64; m_ph = mfr_pkg::PH_H1; m_crc = 16'hffff; m_acc = 0;
    m_sh = 0; m_size = 0; m_used = 0; m_hlen = 0; m_src = 0; m_dmatch = 0;
    m_err = mfr_pkg::ST_OK; m_left = 0; m_crclo = 0; m_fill = 0;
  endfunction

  function automatic void push_verdict(input logic [3:0] st, input logic [8:0] pc);
    mfr_pkg::result_t r;
    r = '0;
    r.kind = 1'b1; r.status = st; r.is_query = m_src[7]; r.reply_id = m_src[6:0];
    r.payload_count = pc; r.command_fill = m_fill;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    int r;
    mfr_pkg::result_t d;
    logic [31:0] v;
    logic [15:0] rx;
    logic [8:0] pc;
    logic [3:0] st;
    case (m_ph)
      mfr_pkg::PH_H1: if (b == mfr_pkg::Hdr1) begin
        m_crc = crc_byte(16'hffff, b); m_ph = mfr_pkg::PH_H2;
      end
      mfr_pkg::PH_H2: begin
        m_crc = crc_byte(m_crc, b);
        m_ph = (b == mfr_pkg::Hdr2) ? mfr_pkg::PH_SRC : mfr_pkg::PH_H1;
      end
      mfr_pkg::PH_SRC: begin
        m_crc = crc_byte(m_crc, b); m_src = b; m_ph = mfr_pkg::PH_DST;
      end
      mfr_pkg::PH_DST: begin
        m_crc = crc_byte(m_crc, b); m_dmatch = (b == m_own);
        m_acc = 0; m_sh = 0; m_hlen = 4; m_ph = mfr_pkg::PH_SIZE;
      end
      mfr_pkg::PH_SIZE: begin
        m_crc = crc_byte(m_crc, b); m_hlen++;
        r = varuint_feed(b);
        if (r != 0) begin
          m_size = (r == 1) ? m_acc : 32'hffffffff;
          m_acc = 0; m_sh = 0;
          if (m_size > mfr_pkg::FrameBytes - m_hlen) begin
            m_ph = mfr_pkg::PH_H1; push_verdict(mfr_pkg::ST_LARGE, 0);
          end else begin
            m_used = 0; m_err = mfr_pkg::ST_OK; m_left = 0;
            if (m_size == 0) begin
              m_err = mfr_pkg::ST_MALF; m_ph = mfr_pkg::PH_CRCLO;
            end else m_ph = mfr_pkg::PH_SUB;
          end
        end
      end
      mfr_pkg::PH_SUB, mfr_pkg::PH_CHAN, mfr_pkg::PH_LEN, mfr_pkg::PH_PAY,
      mfr_pkg::PH_REST: begin
        m_crc = crc_byte(m_crc, b); m_used++;
        if (m_ph == mfr_pkg::PH_PAY) begin
          d = '0; d.data_byte = b; expected_q.push_back(d);
          if (m_left > 0) m_left--;
          if (m_left == 0) m_ph = mfr_pkg::PH_REST;
        end else if (m_ph != mfr_pkg::PH_REST) begin
          r = varuint_feed(b);
          if (r == 2) inner_fail(mfr_pkg::ST_MALF);
          else if (r == 1) begin
            v = m_acc;
            if (m_ph == mfr_pkg::PH_SUB) begin
              if (v != m_sub) inner_fail(mfr_pkg::ST_SUB); else m_ph = mfr_pkg::PH_CHAN;
              m_acc = 0; m_sh = 0;
            end else if (m_ph == mfr_pkg::PH_CHAN) begin
              if (v != 1) inner_fail(mfr_pkg::ST_CHAN); else m_ph = mfr_pkg::PH_LEN;
              m_acc = 0; m_sh = 0;
            end else begin
              if (v > m_size - m_used) inner_fail(mfr_pkg::ST_LEN);
              else begin
                m_left = v[8:0];
                m_ph = (v != 0) ? mfr_pkg::PH_PAY : mfr_pkg::PH_REST;
              end
            end
          end
        end
        if (m_used >= m_size) begin
          if (m_ph == mfr_pkg::PH_SUB || m_ph == mfr_pkg::PH_CHAN ||
              m_ph == mfr_pkg::PH_LEN) inner_fail(mfr_pkg::ST_MALF);
          m_ph = mfr_pkg::PH_CRCLO;
        end
      end
      mfr_pkg::PH_CRCLO: begin
        m_crclo = b; m_ph = mfr_pkg::PH_CRCHI;
      end
      mfr_pkg::PH_CRCHI: begin
        rx = {b, m_crclo};
        pc = (m_err == mfr_pkg::ST_OK) ? m_acc[8:0] : 9'd0;
        if (rx != m_crc) st = mfr_pkg::ST_CRC;
        else if (!m_dmatch) st = mfr_pkg::ST_NOTOURS;
        else if (m_err != mfr_pkg::ST_OK) st = m_err;
        else if (m_fill + pc > mfr_pkg::CommandBytes) begin
          st = mfr_pkg::ST_OVER; m_fill = 0;
        end else begin
          st = mfr_pkg::ST_OK; m_fill = m_fill + pc;
        end
        m_ph = mfr_pkg::PH_H1;
        push_verdict(st, pc);
      end
      default: m_ph = mfr_pkg::PH_H1;
    endcase
  endfunction

  // sender
  task automatic send_byte(input logic [7:0] b);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
    in_valid = 1'b1;
    rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == mfr_pkg::CfgOwnId) m_own = val; else m_sub = val[6:0];
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(negedge clk); guard++;
    end
    repeat (20) @(negedge clk);
  endtask

  function automatic void put_varuint(input logic [31:0] v);
    do begin
      frame_buf.push_back({(v > 32'd127), v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endfunction

  // builds a frame into frame_buf; flaw selects a broken field
  function automatic void build_frame(input logic [7:0] src, input logic [7:0] dst,
                                      input int npay, input int flaw);
    logic [7:0] body[$];
    logic [15:0] c;
    logic [7:0] tmp[$];
    frame_buf = {};
    put_varuint((flaw == 1) ? 32'($urandom_range(127)) : {25'd0, m_sub});
    put_varuint((flaw == 2) ? 32'($urandom_range(3)) : 32'd1);
    put_varuint((flaw == 3) ? 32'(npay + 1 + $urandom_range(3)) : 32'(npay));
    for (int i = 0; i < npay; i++) frame_buf.push_back(8'($urandom));
    if (flaw == 4) frame_buf.push_back(8'($urandom));
    body = frame_buf;
    frame_buf = {mfr_pkg::Hdr1, mfr_pkg::Hdr2, src, dst};
    put_varuint(32'(body.size()));
    tmp = frame_buf;
    frame_buf = {tmp, body};
    c = 16'hffff;
    foreach (frame_buf[i]) c = crc_byte(c, frame_buf[i]);
    if (flaw == 5) c = c ^ (16'd1 << $urandom_range(15));
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endfunction

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i]);
  endtask

  // receiver and checker
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_recv) out_ready <= 1'b0;
      else out_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    mfr_pkg::result_t a, e;
    if (!rst && out_valid && out_ready) begin
      a = {kind, data_byte, status, is_query, reply_id, payload_count, command_fill};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, a);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (a != e) begin
          $display("%0t mismatch expected %h actual %h", $time, e, a);
          failed = 1'b1;
        end
      end
    end
  end

  typedef struct {
    logic [7:0] b;
    bit         chk;
    mfr_pkg::result_t res;
  } stim_row_t;

  stim_row_t stim_table[$];

  function automatic void add_row(input logic [7:0] b);
    stim_row_t s;
    s.b = b; s.chk = 0; s.res = '0;
    stim_table.push_back(s);
  endfunction

  initial begin
    int fl, npay, guard, nr, nb;
    logic [7:0] dst;
    stim_row_t s;
    failed = 0; send_idle = 0; recv_idle = 0; hold_recv = 0;
    in_valid = 0; rx_byte = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    rst = 1;
    predictor_reset();
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: wrong second header, oversize, all-ones size, extremes
    add_row(8'h00); add_row(8'hff); add_row(mfr_pkg::Hdr1); add_row(mfr_pkg::Hdr1);
    add_row(mfr_pkg::Hdr1); add_row(mfr_pkg::Hdr2); add_row(8'hff); add_row(8'h01);
    add_row(8'hff); add_row(8'h01);                  // size 255 oversize
    s.b = 8'h80; s.chk = 1; s.res = '0;
    s.res.kind = 1; s.res.status = mfr_pkg::ST_LARGE; s.res.is_query = 1;
    s.res.reply_id = 7'h7f;
    stim_table[$].chk = 1; stim_table[$].res = s.res;
    add_row(mfr_pkg::Hdr1); add_row(mfr_pkg::Hdr2); add_row(8'h00); add_row(8'h00);
    for (int i = 0; i < 5; i++) add_row(8'hff);      // never-ending size
    stim_table[$].chk = 1;
    stim_table[$].res = '0;
    stim_table[$].res.kind = 1; stim_table[$].res.status = mfr_pkg::ST_LARGE;
    foreach (stim_table[i]) begin
      if (stim_table[i].chk && expected_q.size() == 0) begin
        send_byte(stim_table[i].b);
        if (expected_q.size() != 1 || expected_q[0] != stim_table[i].res) begin
          $display("%0t table row %0d expected %h", $time, i, stim_table[i].res);
          failed = 1;
        end
      end else send_byte(stim_table[i].b);
    end
    // empty body, each flaw once, max payload
    frame_buf = {mfr_pkg::Hdr1, mfr_pkg::Hdr2, 8'h05, 8'h01, 8'h00, 8'h00, 8'h00};
    send_frame();
    for (int f = 0; f < 6; f++) begin
      build_frame(8'h85, 8'h01, 3, f); send_frame();
    end
    build_frame(8'h00, 8'h01, 246, 0); send_frame();
    build_frame(8'h01, 8'h01, 8, 0); send_frame();     // overflow
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 78; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 78; end
        3: begin send_idle = 12; recv_idle = 12; end
        default: begin send_idle = $urandom_range(30); recv_idle = $urandom_range(30); end
      endcase
      case (ph)
        1: begin write_reg(mfr_pkg::CfgOwnId, 8'hff); write_reg(mfr_pkg::CfgSubCode, 8'h7f); end
        2: begin write_reg(mfr_pkg::CfgOwnId, 8'h00); write_reg(mfr_pkg::CfgSubCode, 8'h00); end
        3: begin
          write_reg(mfr_pkg::CfgOwnId, 8'($urandom));
          write_reg(mfr_pkg::CfgSubCode, 8'($urandom));
        end
        default: begin
          write_reg(mfr_pkg::CfgOwnId, 8'h01); write_reg(mfr_pkg::CfgSubCode, 8'h40);
        end
      endcase
      if (ph == 4) begin
        fork
          begin
            hold_recv = 1;
            repeat (300) @(negedge clk);
            hold_recv = 0;
          end
          begin
            build_frame(8'h02, m_own, 40, 0); send_frame();
          end
        join
      end
      nr = 0;
      while (nr < 25) begin
        fl = $urandom_range(9);
        dst = ($urandom_range(9) == 0) ? 8'($urandom) : m_own;
        npay = ($urandom_range(19) == 0) ? $urandom_range(240) : $urandom_range(8);
        if (fl >= 7) begin
          nb = $urandom_range(1, 6);
          repeat (nb) begin
            send_byte(($urandom_range(3) == 0) ? mfr_pkg::Hdr1 : 8'($urandom));
          end
          nr += nb;
        end else begin
          build_frame(8'($urandom), dst, npay, (fl < 4) ? 0 : fl - 3 + $urandom_range(2));
          send_frame();
          nr += frame_buf.size();
        end
      end
      // flush any partial frame
      repeat (300) begin
        if (m_ph != mfr_pkg::PH_H1) send_byte(8'($urandom));
      end
      while (m_ph != mfr_pkg::PH_H1) send_byte(8'h00);
      drain();
    end

    guard = 0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(negedge clk); guard++;
    end
    repeat (20) @(negedge clk);
    if (!failed && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/mfr_pkg.sv
rtl/mfr_front.sv
rtl/mfr_queue.sv
rtl/mfr_back.sv
rtl/multiplex_frame_receiver_unit.sv
rtl/mfr_checker.sv
verif/tb_top.sv
